FILE: design/uapq_pkg.sv
// ----------------------------------------------------------------------------
// uapq_pkg
// Shared types and codes for the unsorted array min/max priority queue:
// request and response transfers, cell control, stored entries and the
// scan wave that runs along the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package uapq_pkg;

   // Request operation codes
   typedef enum logic [1:0] {
      FUNC_INSERT      = 2'd0,
      FUNC_EXTRACT_MAX = 2'd1,
      FUNC_EXTRACT_MIN = 2'd2,
      FUNC_CLEAR       = 2'd3
   } func_type;

   // Response status codes
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_POST
   } state_type;

   localparam int PAYLOAD_W  = 32;
   localparam int PRIORITY_W = 16;
   localparam int COUNT_W    = 5;

   typedef struct packed {
      func_type                func;
      logic [PAYLOAD_W-1:0]    payload_in;
      logic [PRIORITY_W-1:0]   priority_in;
   } req_type;

   typedef struct packed {
      logic [PAYLOAD_W-1:0]    payload_out;
      logic [PRIORITY_W-1:0]   priority_out;
      status_type              status;
      logic [COUNT_W-1:0]      count;
      logic                    is_empty;
      logic                    is_full;
   } rsp_type;

   // One stored queue entry
   typedef struct packed {
      logic [PAYLOAD_W-1:0]    payload;
      logic [PRIORITY_W-1:0]   prio;
   } entry_type;

   // Best candidate so far, handed from cell to cell
   typedef struct packed {
      logic                    has;
      logic [PAYLOAD_W-1:0]    payload;
      logic [PRIORITY_W-1:0]   prio;
   } wave_type;

   // Per-cell control from the controller
   typedef struct packed {
      logic                    load;
      logic                    shift;
      logic                    occupied;
      logic                    want_max;
   } cell_ctrl_type;

endpackage : uapq_pkg

`default_nettype wire

FILE: design/unsorted_array_min_max_priority_queue.sv
// ----------------------------------------------------------------------------
// unsorted_array_min_max_priority_queue
// Bounded priority queue kept in insertion order in a chain of cells.
// Order: each request goes through ST_POST to the response register; an
//   extract on a non-empty queue first runs the scan wave in ST_SCAN.
// Flow: one request at a time; the scan wave passes one cell per cycle,
//   and req_ready stays low until the response is registered, longer
//   while rsp_ready holds off.
// Reset: synchronous, clears the count, the state and rsp_valid; entries
//   are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module unsorted_array_min_max_priority_queue #(
   parameter int CAPACITY = 16
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  uapq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output uapq_pkg::rsp_type rsp_data
);
   import uapq_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   // Controller registers
   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      scan_ff, scan_in;
   logic                  want_max_ff, want_max_in;
   logic [PAYLOAD_W-1:0]  res_payload_ff, res_payload_in;
   logic [PRIORITY_W-1:0] res_priority_ff, res_priority_in;
   status_type            res_status_ff, res_status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  req_fire;
   logic                  do_insert;
   logic                  scan_last;
   entry_type             ins_entry;

   // Cell chain wiring
   entry_type             cell_entry [CAPACITY];
   wave_type              cell_wave  [CAPACITY];
   logic [IDX_W-1:0]      cell_wave_idx [CAPACITY];
   cell_ctrl_type         cell_ctrl  [CAPACITY];

   assign req_fire  = req_valid && req_ready;
   assign do_insert = req_fire && (req_data.func == FUNC_INSERT) &&
                      (count_ff < CNT_W'(CAPACITY));
   assign scan_last = (state_ff == ST_SCAN) && (scan_ff == CNT_W'(CAPACITY));
   assign ins_entry.payload = req_data.payload_in;
   assign ins_entry.prio    = req_data.priority_in;

   // Build the cell chain
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam logic [IDX_W-1:0] CELL_IDX = IDX_W'(i);
      wave_type          prev_wave;
      logic [IDX_W-1:0]  prev_idx;
      entry_type         upper_entry;

      if (i == 0) begin : g_head
         assign prev_wave = '0;
         assign prev_idx  = '0;
      end else begin : g_link
         assign prev_wave = cell_wave[i-1];
         assign prev_idx  = cell_wave_idx[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign upper_entry = cell_entry[i];
      end else begin : g_up
         assign upper_entry = cell_entry[i+1];
      end

      assign cell_ctrl[i].load     = do_insert &&
                                     (count_ff == CNT_W'(i));
      assign cell_ctrl[i].shift    = scan_last && cell_wave[CAPACITY-1].has &&
                                     (CELL_IDX >= cell_wave_idx[CAPACITY-1]);
      assign cell_ctrl[i].occupied = CNT_W'(i) < count_ff;
      assign cell_ctrl[i].want_max = want_max_ff;

      uapq_cell #(
         .IDX_W (IDX_W)
      ) u_cell (
         .clock         (clock),
         .cell_idx      (CELL_IDX),
         .ctrl          (cell_ctrl[i]),
         .ins_entry     (ins_entry),
         .next_entry    (upper_entry),
         .entry         (cell_entry[i]),
         .wave_prev     (prev_wave),
         .wave_prev_idx (prev_idx),
         .wave          (cell_wave[i]),
         .wave_idx      (cell_wave_idx[i])
      );
   end

   // Next state and result
   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      scan_in         = scan_ff;
      want_max_in     = want_max_ff;
      res_payload_in  = res_payload_ff;
      res_priority_in = res_priority_ff;
      res_status_in   = res_status_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_data_in     = rsp_data_ff;
      req_ready       = 1'b0;

      // Drop the response once it is taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               res_payload_in  = '0;
               res_priority_in = '0;
               res_status_in   = STATUS_OK;
               scan_in         = '0;
               want_max_in     = (req_data.func == FUNC_EXTRACT_MAX);
               state_in        = ST_POST;
               case (req_data.func)
                  FUNC_INSERT: begin
                     if (do_insert) begin
                        count_in = count_ff + CNT_W'(1);
                     end else begin
                        res_status_in = STATUS_FULL;
                     end
                  end
                  FUNC_EXTRACT_MAX, FUNC_EXTRACT_MIN: begin
                     if (count_ff == '0) begin
                        res_status_in = STATUS_EMPTY;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  FUNC_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     count_in = count_ff;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // Wait for the wave to leave the last cell, then close the gap
            scan_in = scan_ff + CNT_W'(1);
            if (scan_last) begin
               res_payload_in  = cell_wave[CAPACITY-1].payload;
               res_priority_in = cell_wave[CAPACITY-1].prio;
               count_in        = count_ff - CNT_W'(1);
               scan_in         = '0;
               state_in        = ST_POST;
            end
         end
         ST_POST: begin
            // Hand the result to the output register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.payload_out  = res_payload_ff;
               rsp_data_in.priority_out = res_priority_ff;
               rsp_data_in.status       = res_status_ff;
               rsp_data_in.count        = COUNT_W'(count_ff);
               rsp_data_in.is_empty     = (count_ff == '0);
               rsp_data_in.is_full      = (count_ff == CNT_W'(CAPACITY));
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result registers
   always_ff @(posedge clock) begin
      want_max_ff     <= want_max_in;
      res_payload_ff  <= res_payload_in;
      res_priority_ff <= res_priority_in;
      res_status_ff   <= res_status_in;
      rsp_data_ff     <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule : unsorted_array_min_max_priority_queue

`default_nettype wire

FILE: design/uapq_cell.sv
// ----------------------------------------------------------------------------
// uapq_cell
// One queue slot. Holds one entry, loads it on insert, takes its upper
// neighbor's entry when the gap closes, and registers one stage of the
// min/max scan wave.
// ----------------------------------------------------------------------------
`default_nettype none

module uapq_cell #(
   parameter int IDX_W = 4
) (
   input  wire                     clock,
   input  wire  [IDX_W-1:0]        cell_idx,
   input  uapq_pkg::cell_ctrl_type ctrl,
   input  uapq_pkg::entry_type     ins_entry,
   input  uapq_pkg::entry_type     next_entry,
   output uapq_pkg::entry_type     entry,
   input  uapq_pkg::wave_type      wave_prev,
   input  wire  [IDX_W-1:0]        wave_prev_idx,
   output uapq_pkg::wave_type      wave,
   output logic [IDX_W-1:0]        wave_idx
);
   import uapq_pkg::*;

   entry_type         entry_ff, entry_in;
   wave_type          wave_ff, wave_in;
   logic [IDX_W-1:0]  wave_idx_ff, wave_idx_in;
   logic              better;
   logic              take;

   // Load on insert, shift down when this or an earlier entry is removed
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.load) begin
         entry_in = ins_entry;
      end else if (ctrl.shift) begin
         entry_in = next_entry;
      end
   end

   // Strict compare so the earliest entry wins a tie
   always_comb begin
      if (ctrl.want_max) begin
         better = entry_ff.prio > wave_prev.prio;
      end else begin
         better = entry_ff.prio < wave_prev.prio;
      end
      take = ctrl.occupied && (!wave_prev.has || better);
      if (take) begin
         wave_in.has      = 1'b1;
         wave_in.payload  = entry_ff.payload;
         wave_in.prio     = entry_ff.prio;
         wave_idx_in      = cell_idx;
      end else begin
         wave_in          = wave_prev;
         wave_idx_in      = wave_prev_idx;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff    <= entry_in;
      wave_ff     <= wave_in;
      wave_idx_ff <= wave_idx_in;
   end

   assign entry    = entry_ff;
   assign wave     = wave_ff;
   assign wave_idx = wave_idx_ff;

endmodule : uapq_cell

`default_nettype wire

FILE: dv/tb_unsorted_array_min_max_priority_queue.sv
// ----------------------------------------------------------------------------
// tb_unsorted_array_min_max_priority_queue
// Self-checking bench for the unsorted array min/max priority queue. A short
// table of directed requests drives empty and full cases, priority extremes
// and ties. A long random run then moves the queue between filling and
// draining. Responses are checked against a queue model or a pinned row.
// ----------------------------------------------------------------------------
module tb_unsorted_array_min_max_priority_queue;
   timeunit 1ns;
   timeprecision 1ps;

   import uapq_pkg::*;

   localparam int QUEUE_DEPTH      = 16;
   localparam int RANDOM_ITEMS     = 1250;
   localparam int QUIET_FROM       = RANDOM_ITEMS * 85 / 100;
   localparam int SENDER_PAUSE_AT  = 700;
   localparam int LONG_HOLD_AT     = 300;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES     = 2 * (QUEUE_DEPTH + 2);
   localparam int LIMIT_CYCLES     = 250000;

   typedef struct {
      req_type req;
      bit      pinned;
      rsp_type want;
   } stim_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // Queue model: entries in insertion order
   logic [PAYLOAD_W-1:0]  held_payload [QUEUE_DEPTH];
   logic [PRIORITY_W-1:0] held_rank [QUEUE_DEPTH];
   int unsigned           held_count = 0;

   rsp_type      pending_results[$];
   stim_row_type directed_rows[$];

   // Fixed response for the request now on the bus, when the table gives one
   bit      pin_valid = 1'b0;
   rsp_type pin_rsp = '0;

   bit idle_enable = 1'b1;
   int unsigned cycle_count = 0;
   int unsigned req_transfers = 0;
   int unsigned rsp_transfers = 0;
   int unsigned fail_count = 0;
   int unsigned full_drops = 0;
   int unsigned empty_extracts = 0;
   int unsigned clears_seen = 0;

   unsorted_array_min_max_priority_queue #(
      .CAPACITY(QUEUE_DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Response with zero payload and flags derived from the depth
   function automatic rsp_type status_result(input status_type code, input int unsigned depth);
      rsp_type r;
      r = '0;
      r.status = code;
      r.count = COUNT_W'(depth);
      r.is_empty = (depth == 0);
      r.is_full = (depth == QUEUE_DEPTH);
      return r;
   endfunction

   // Apply one request to the queue model and return the response it yields
   function automatic rsp_type apply_request(input req_type r);
      rsp_type               rsp;
      status_type            code;
      int unsigned           pick;
      logic [PAYLOAD_W-1:0]  out_payload;
      logic [PRIORITY_W-1:0] out_rank;
      code = STATUS_OK;
      out_payload = '0;
      out_rank = '0;
      case (r.func)
         FUNC_INSERT: begin
            if (held_count >= QUEUE_DEPTH) begin
               code = STATUS_FULL;
               full_drops++;
            end else begin
               held_payload[held_count] = r.payload_in;
               held_rank[held_count] = r.priority_in;
               held_count++;
            end
         end
         FUNC_EXTRACT_MAX, FUNC_EXTRACT_MIN: begin
            if (held_count == 0) begin
               code = STATUS_EMPTY;
               empty_extracts++;
            end else begin
               // earliest entry wins a tie, so only a strict compare moves the pick
               pick = 0;
               for (int i = 1; i < held_count; i++) begin
                  if (r.func == FUNC_EXTRACT_MAX ? held_rank[i] > held_rank[pick]
                                                 : held_rank[i] < held_rank[pick])
                     pick = i;
               end
               out_payload = held_payload[pick];
               out_rank = held_rank[pick];
               // close the gap
               for (int i = pick; i + 1 < held_count; i++) begin
                  held_payload[i] = held_payload[i + 1];
                  held_rank[i] = held_rank[i + 1];
               end
               held_count--;
            end
         end
         default: begin
            held_count = 0;
            clears_seen++;
         end
      endcase
      rsp = status_result(code, held_count);
      rsp.payload_out = out_payload;
      rsp.priority_out = out_rank;
      return rsp;
   endfunction

   // Compare a response transfer against the oldest expectation
   task automatic check_response(input rsp_type got);
      rsp_type want;
      if (pending_results.size() == 0) begin
         $error("response with nothing outstanding: %p", got);
         fail_count++;
      end else begin
         want = pending_results.pop_front();
         if (got.payload_out !== want.payload_out) begin
            $error("payload_out: expected %h, got %h", want.payload_out, got.payload_out);
            fail_count++;
         end
         if (got.priority_out !== want.priority_out) begin
            $error("priority_out: expected %h, got %h", want.priority_out, got.priority_out);
            fail_count++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
         end
         if (got.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, got.count);
            fail_count++;
         end
         if (got.is_empty !== want.is_empty) begin
            $error("is_empty: expected %b, got %b", want.is_empty, got.is_empty);
            fail_count++;
         end
         if (got.is_full !== want.is_full) begin
            $error("is_full: expected %b, got %b", want.is_full, got.is_full);
            fail_count++;
         end
      end
   endtask

   // Watch both channels; check responses before logging a new request
   always @(posedge clock) begin : scoreboard
      rsp_type predicted;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            check_response(rsp_data);
            rsp_transfers++;
         end
         if (req_valid && req_ready) begin
            predicted = apply_request(req_data);
            if (pin_valid)
               predicted = pin_rsp;
            pending_results.push_back(predicted);
            req_transfers++;
         end
      end
   end

   // Timeout guard
   initial begin : watchdog
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("unsorted_array_min_max_priority_queue test failed");
      $finish;
   end

   // Response side: random stall bursts, one long hold, none near the end
   initial begin : response_side
      int unsigned stall_left;
      bit          long_hold_done;
      stall_left = 0;
      long_hold_done = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_ready = 1'b0;
         end else if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else if (!long_hold_done && rsp_transfers >= LONG_HOLD_AT) begin
            long_hold_done = 1'b1;
            rsp_ready = 1'b0;
            stall_left = LONG_HOLD_CYCLES - 1;
         end else if (idle_enable && (cycle_count / 500) % 4 != 3
                      && $urandom_range(4) == 0) begin
            rsp_ready = 1'b0;
            stall_left = $urandom_range(4, 0);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   function automatic void add_row(input func_type op, input logic [PAYLOAD_W-1:0] pay,
                                   input logic [PRIORITY_W-1:0] rank, input bit pinned,
                                   input rsp_type want);
      stim_row_type row;
      row.req.func = op;
      row.req.payload_in = pay;
      row.req.priority_in = rank;
      row.pinned = pinned;
      row.want = want;
      directed_rows.push_back(row);
   endfunction

   // Random request; fill phases favor inserts, drain phases favor extracts
   function automatic req_type random_request(input bit fill_phase);
      req_type r;
      int      roll;
      r.payload_in = $urandom;
      case ($urandom_range(3))
         0: r.priority_in = PRIORITY_W'($urandom_range(7));
         1: r.priority_in = $urandom_range(1) ? '1 : '0;
         default: r.priority_in = PRIORITY_W'($urandom);
      endcase
      roll = $urandom_range(99);
      if (roll < 2)
         r.func = FUNC_CLEAR;
      else if (roll < (fill_phase ? 70 : 30))
         r.func = FUNC_INSERT;
      else if ($urandom_range(1))
         r.func = FUNC_EXTRACT_MAX;
      else
         r.func = FUNC_EXTRACT_MIN;
      return r;
   endfunction

   // Offer one request and hold it until the transfer; call at a falling edge
   task automatic send_request(input req_type item, input bit may_idle, input bit pinned,
                               input rsp_type pinned_rsp);
      if (may_idle && $urandom_range(3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(5, 1)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = item;
      pin_valid = pinned;
      pin_rsp = pinned_rsp;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   initial begin : stimulus
      bit sender_idle;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;

      // Empty queue, priority extremes and ties, then fill to capacity
      add_row(FUNC_EXTRACT_MAX, '0, '0, 1'b1, status_result(STATUS_EMPTY, 0));
      add_row(FUNC_EXTRACT_MIN, '1, '1, 1'b1, status_result(STATUS_EMPTY, 0));
      add_row(FUNC_CLEAR, '0, '0, 1'b1, status_result(STATUS_OK, 0));
      add_row(FUNC_INSERT, '1, '1, 1'b1, status_result(STATUS_OK, 1));
      add_row(FUNC_INSERT, '0, '0, 1'b1, status_result(STATUS_OK, 2));
      add_row(FUNC_INSERT, 32'hA5A5_A5A5, '1, 1'b1, status_result(STATUS_OK, 3));
      add_row(FUNC_INSERT, 32'h5A5A_5A5A, '0, 1'b1, status_result(STATUS_OK, 4));
      add_row(FUNC_EXTRACT_MAX, '0, '0, 1'b0, '0);
      add_row(FUNC_EXTRACT_MIN, '0, '0, 1'b0, '0);
      for (int i = 0; i < QUEUE_DEPTH - 2; i++)
         add_row(FUNC_INSERT, 32'h1111_1111 * (i + 1), PRIORITY_W'(i * 4099), 1'b0, '0);
      add_row(FUNC_INSERT, 32'hDEAD_0001, 16'h8000, 1'b1,
              status_result(STATUS_FULL, QUEUE_DEPTH));
      add_row(FUNC_EXTRACT_MIN, '0, '0, 1'b0, '0);
      add_row(FUNC_CLEAR, '0, '0, 1'b1, status_result(STATUS_OK, 0));

      // Hold reset, then release it
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].req, 1'b1, directed_rows[i].pinned,
                      directed_rows[i].want);

      for (int idx = 0; idx < RANDOM_ITEMS; idx++) begin
         if (idx == QUIET_FROM)
            idle_enable = 1'b0;
         // pause until the queue has answered everything
         if (idx == SENDER_PAUSE_AT) begin
            req_valid = 1'b0;
            do @(negedge clock); while (pending_results.size() != 0);
         end
         sender_idle = idle_enable && (idx / 100) % 3 != 2;
         send_request(random_request((idx / 40) % 2 == 0), sender_idle, 1'b0, '0);
      end
      req_valid = 1'b0;
      pin_valid = 1'b0;

      // Drain, then give the block time to show any stray response
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Ran %0d requests (%0d from the table) and checked %0d responses in %0d cycles.",
               req_transfers, directed_rows.size(), rsp_transfers, cycle_count);
      $display("Saw %0d inserts refused while full, %0d extracts on empty, %0d clears.",
               full_drops, empty_extracts, clears_seen);
      if (fail_count == 0) begin
         $display("unsorted_array_min_max_priority_queue test passed");
      end else begin
         $display("unsorted_array_min_max_priority_queue test failed");
      end
      $finish;
   end

endmodule
